/* hdl/cse_pkg.sv */
// Package with the payload types, register indexes and sizes of the CAN signal encoder.
package cse_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned FrameW     = 8 * FrameBytes;
  localparam int unsigned PhysW      = 48;
  localparam int unsigned NumW       = PhysW + 2;  // 2|n| + |f| stays below 2^50
  localparam int unsigned DenW       = PhysW + 1;  // 2|f| fits in 49 bits
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegStartBit  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSigLength = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffset    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFactor    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPhysMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPhysMax   = 3'd5;

  typedef struct packed {
    logic [FrameW-1:0]       frame_in;
    logic signed [PhysW-1:0] phys_value;
    logic                    value_numeric;
  } in_beat_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_out;
    logic [FrameW-1:0] raw_code;
    logic              encode_ok;
  } out_beat_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              numeric;
    logic              force_zero;
  } side_t;

endpackage

/* hdl/cse_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module cse_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [cse_pkg::NumW-1:0]  num_i,
  input  logic [cse_pkg::DenW-1:0]  den_i,
  input  cse_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [cse_pkg::NumW-1:0]  quo_o,
  output cse_pkg::side_t            side_o
);
  import cse_pkg::*;

  logic            vld_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] quo_q [NumW];
  side_t           side_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            vin;
    logic [NumW-1:0] nin;
    logic [DenW-1:0] din;
    logic [DenW-1:0] rin;
    logic [NumW-1:0] qin;
    side_t           sin;
    logic [DenW:0]   trial;
    logic            ge;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign nin = num_i;
      assign din = den_i;
      assign rin = '0;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign nin = num_q[k-1];
      assign din = den_q[k-1];
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign sin = side_q[k-1];
    end

    always_comb begin
      trial = {rin, nin[NumW-1-k]};
      ge    = trial >= {1'b0, din};
      rem_d = ge ? DenW'(trial - {1'b0, din}) : trial[DenW-1:0];
      quo_d = qin;
      quo_d[NumW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= nin;
      den_q[k]  <= din;
      rem_q[k]  <= rem_d;
      quo_q[k]  <= quo_d;
      side_q[k] <= sin;
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

/* hdl/can_signal_encoder.sv */
// Top level of the CAN signal encoder: scaling, clamping, division and frame packing.
//
// A beat is taken at each rising edge where start_i is high and busy_o is low; busy_o
// is always low, so a new beat can enter every cycle. Each beat carries a frame, a
// signed Q31.16 value and a numeric flag. Exactly one result beat comes out per input
// beat, in order, on out_o for one cycle while done_o is high.
// The pipeline has three front stages (clamp, offset subtract, magnitudes), one stage
// per quotient bit of the 50-bit restoring divider, and one packing stage.
// Throughput is one beat per cycle, set by the fully pipelined divider.
// The receiver cannot stall, so results are never held back.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write only while no beat is in flight (not enforced by the block); register indexes
// follow the register list from 0. Reset clears all valid bits and loads the register
// defaults: start bit 0, length 8, offset 0, factor 1.0, bounds 0 and 0 (clamp off).
module can_signal_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  cse_pkg::in_beat_t             in_i,
  output logic                          done_o,
  output cse_pkg::out_beat_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [cse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cse_pkg::PhysW-1:0]     cfg_data_i
);
  import cse_pkg::*;

  logic [5:0]              start_bit_q;
  logic [6:0]              sig_len_q;
  logic signed [PhysW-1:0] offset_q;
  logic signed [PhysW-1:0] factor_q;
  logic signed [PhysW-1:0] pmin_q;
  logic signed [PhysW-1:0] pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bit_q <= 6'd0;
      sig_len_q   <= 7'd8;
      offset_q    <= '0;
      factor_q    <= PhysW'(65536);
      pmin_q      <= '0;
      pmax_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartBit:  start_bit_q <= cfg_data_i[5:0];
        RegSigLength: sig_len_q   <= cfg_data_i[6:0];
        RegOffset:    offset_q    <= cfg_data_i;
        RegFactor:    factor_q    <= cfg_data_i;
        RegPhysMin:   pmin_q      <= cfg_data_i;
        RegPhysMax:   pmax_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage 1: clamp against the sorted bounds, unless both bounds are equal.
  logic                    v1_q;
  logic signed [PhysW-1:0] val1_q;
  logic [FrameW-1:0]       frame1_q;
  logic                    num1_q;
  logic signed [PhysW-1:0] lo, hi, val1_d;

  always_comb begin
    lo = (pmin_q > pmax_q) ? pmax_q : pmin_q;
    hi = (pmin_q > pmax_q) ? pmin_q : pmax_q;
    val1_d = in_i.phys_value;
    if (pmin_q != pmax_q) begin
      if (in_i.phys_value < lo) begin
        val1_d = lo;
      end else if (in_i.phys_value > hi) begin
        val1_d = hi;
      end
    end
  end

  // Stage 2: subtract the offset.
  logic                    v2_q;
  logic signed [PhysW:0]   n2_q;
  logic [FrameW-1:0]       frame2_q;
  logic                    num2_q;

  // Stage 3: magnitudes and the rounding numerator and denominator.
  logic                    v3_q;
  logic [NumW-1:0]         num3_q;
  logic [DenW-1:0]         den3_q;
  side_t                   side3_q;
  logic [PhysW:0]          an;
  logic [PhysW-1:0]        af;
  logic                    neg;

  always_comb begin
    an  = n2_q[PhysW] ? (PhysW+1)'(0) - n2_q : n2_q;
    af  = factor_q[PhysW-1] ? PhysW'(0) - factor_q : factor_q;
    neg = n2_q[PhysW] != factor_q[PhysW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val1_q   <= val1_d;
    frame1_q <= in_i.frame_in;
    num1_q   <= in_i.value_numeric;

    n2_q     <= (PhysW+1)'(val1_q) - (PhysW+1)'(offset_q);
    frame2_q <= frame1_q;
    num2_q   <= num1_q;

    num3_q             <= {an, 1'b0} + NumW'(af);
    den3_q             <= (af == '0) ? DenW'(1) : {af, 1'b0};
    side3_q.frame      <= frame2_q;
    side3_q.numeric    <= num2_q;
    // A zero factor or a negative quotient both give raw code zero.
    side3_q.force_zero <= (factor_q == '0) || neg;
  end

  logic            dv;
  logic [NumW-1:0] quo;
  side_t           dside;

  cse_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .side_i  (side3_q),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (dside)
  );

  // Packing stage: saturate and insert into the frame; a non-numeric beat keeps its frame.
  logic [6:0]        len_c;
  logic [FrameW-1:0] top, raw, mask;
  out_beat_t         out_d;
  logic              done_q;
  out_beat_t         out_q;

  always_comb begin
    len_c = (sig_len_q > 7'd64) ? 7'd64 : sig_len_q;
    top   = len_c[6] ? '1 : ((FrameW'(1) << len_c[5:0]) - FrameW'(1));
    raw   = dside.force_zero ? '0 : FrameW'(quo);
    if (raw > top) begin
      raw = top;
    end
    mask = top << start_bit_q;
    if (dside.numeric) begin
      out_d.frame_out = (dside.frame & ~mask) | ((raw << start_bit_q) & mask);
      out_d.raw_code  = raw;
      out_d.encode_ok = 1'b1;
    end else begin
      out_d.frame_out = dside.frame;
      out_d.raw_code  = '0;
      out_d.encode_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  a_not_numeric_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_o.encode_ok |-> out_o.raw_code == '0)
    else $error("non-numeric beat with nonzero raw code");

  a_raw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv |=> (out_o.raw_code & ~$past(top)) == '0)
    else $error("raw code exceeds signal length");

  a_done_follows_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv |=> done_o)
    else $error("divider beat lost at packing stage");

endmodule

/* tb/can_signal_encoder_test.sv */
// Testbench for the CAN signal encoder: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module can_signal_encoder_test;
  import cse_pkg::*;

  localparam int unsigned Latency = 54;
  localparam int unsigned IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  in_beat_t in_i = '0;
  logic done_o;
  out_beat_t out_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [PhysW-1:0] cfg_data_i = '0;

  can_signal_encoder dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers.
  logic [5:0] start_bit_q;
  logic [6:0] sig_len_q;
  logic signed [PhysW-1:0] offset_q, factor_q, min_q, max_q;

  in_beat_t pending_beats[$];
  out_beat_t expected_frames[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit hold_sender = 1'b0;

  function automatic out_beat_t predict_beat(in_beat_t b);
    out_beat_t r;
    logic signed [PhysW:0] v, lo, hi, n;
    logic [63:0] an, af, q, top, mask, raw;
    bit neg;
    r.frame_out = b.frame_in;
    r.raw_code = '0;
    r.encode_ok = 1'b0;
    if (!b.value_numeric) return r;
    v = b.phys_value;
    lo = min_q;
    hi = max_q;
    if (lo != hi) begin
      if (lo > hi) begin
        n = lo; lo = hi; hi = n;
      end
      if (v < lo) v = lo;
      if (v > hi) v = hi;
    end
    top = (sig_len_q >= 64) ? '1 : ((64'd1 << sig_len_q) - 64'd1);
    raw = '0;
    if (factor_q != 0) begin
      n = v - offset_q;
      an = n < 0 ? 64'(-n) : 64'(n);
      af = factor_q < 0 ? 64'(0) - 64'(factor_q) : 64'(factor_q);
      q = (2 * an + af) / (2 * af);
      neg = (n < 0) != (factor_q < 0);
      raw = neg ? 64'd0 : q;
      if (raw > top) raw = top;
    end
    mask = top << start_bit_q;
    r.frame_out = (b.frame_in & ~mask) | ((raw << start_bit_q) & mask);
    r.raw_code = raw;
    r.encode_ok = 1'b1;
    return r;
  endfunction

  // Driver: bursts with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    in_beat_t b;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_frames.push_back(predict_beat(in_i));
        accepted++;
      end
      if (gap_left > 0 || hold_sender || pending_beats.size() == 0) begin
        start_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        b = pending_beats.pop_front();
        in_i <= b;
        start_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(30, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        if (expected_frames.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_frames.pop_front();
          checked++;
          if (out_o.frame_out !== e.frame_out) begin
            $error("frame_out: expected %h, got %h", e.frame_out, out_o.frame_out);
            errors++;
          end
          if (out_o.raw_code !== e.raw_code) begin
            $error("raw_code: expected %h, got %h", e.raw_code, out_o.raw_code);
            errors++;
          end
          if (out_o.encode_ok !== e.encode_ok) begin
            $error("encode_ok: expected %b, got %b", e.encode_ok, out_o.encode_ok);
            errors++;
          end
        end
      end
      if (idle_cycles > IdleLimit && !stimulus_done) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [PhysW-1:0] rand48();
    return PhysW'({$urandom(), $urandom()});
  endfunction

  function automatic in_beat_t make_beat(logic [63:0] f, logic [PhysW-1:0] v, bit num);
    in_beat_t b;
    b.frame_in = f;
    b.phys_value = v;
    b.value_numeric = num;
    return b;
  endfunction

  // Values near the raw range so that saturation and rounding both show up.
  function automatic logic [PhysW-1:0] scaled_value();
    case ($urandom_range(5))
      0: return rand48();
      1: return offset_q + factor_q * $signed(48'($urandom_range(300)));
      2: return offset_q + factor_q * $signed(48'($urandom_range(300))) + (factor_q >>> 1);
      3: return PhysW'($signed($urandom_range(2000)) - 1000) <<< 16;
      4: return {1'b1, 47'($urandom())};
      default: return {1'b0, 47'h7fff_ffff_ffff};
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PhysW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      RegStartBit: start_bit_q = data[5:0];
      RegSigLength: sig_len_q = data[6:0];
      RegOffset: offset_q = data;
      RegFactor: factor_q = data;
      RegPhysMin: min_q = data;
      default: max_q = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || start_i || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic setup(logic [5:0] sb, logic [6:0] len, logic [PhysW-1:0] off,
                       logic [PhysW-1:0] fac, logic [PhysW-1:0] lo, logic [PhysW-1:0] hi);
    wait_drained();
    write_reg(RegStartBit, PhysW'(sb));
    write_reg(RegSigLength, PhysW'(len));
    write_reg(RegOffset, off);
    write_reg(RegFactor, fac);
    write_reg(RegPhysMin, lo);
    write_reg(RegPhysMax, hi);
  endtask

  initial begin
    logic [PhysW-1:0] lo, hi;
    start_bit_q = 6'd0;
    sig_len_q = 7'd8;
    offset_q = '0;
    factor_q = 48'sd65536;
    min_q = '0;
    max_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at reset settings: extremes, rounding, negatives, non-numeric.
    pending_beats.push_back(make_beat('0, 48'sd0, 1'b1));
    pending_beats.push_back(make_beat('1, 48'sd0, 1'b1));
    pending_beats.push_back(make_beat('1, 48'h0000_0000_8000, 1'b1));
    pending_beats.push_back(make_beat('0, 48'h0000_0000_7fff, 1'b1));
    pending_beats.push_back(make_beat('1, 48'hffff_ffff_8000, 1'b1));
    pending_beats.push_back(make_beat('1, 48'hffff_ffff_7fff, 1'b1));
    pending_beats.push_back(make_beat('0, 48'h7fff_ffff_ffff, 1'b1));
    pending_beats.push_back(make_beat('1, 48'h8000_0000_0000, 1'b1));
    pending_beats.push_back(make_beat(64'h0123_4567_89ab_cdef, 48'h0000_0064_0000, 1'b0));
    // Zero factor, length zero, length 64, signal running past the frame end.
    setup(6'd4, 7'd12, '0, '0, '0, '0);
    pending_beats.push_back(make_beat('1, 48'h0000_1234_0000, 1'b1));
    setup(6'd10, 7'd0, '0, 48'sd65536, '0, '0);
    pending_beats.push_back(make_beat(64'h5555_aaaa_5555_aaaa, 48'h0000_0005_0000, 1'b1));
    setup(6'd0, 7'd64, 48'h8000_0000_0000, 48'sd1, '0, '0);
    pending_beats.push_back(make_beat('0, 48'h7fff_ffff_ffff, 1'b1));
    setup(6'd63, 7'd127, '0, 48'hffff_ffff_0000, '0, '0);
    pending_beats.push_back(make_beat('0, 48'hfff0_0000_0000, 1'b1));
    pending_beats.push_back(make_beat('0, 48'h0000_0003_0000, 1'b1));
    // Clamp with bounds given in reverse order.
    setup(6'd60, 7'd16, 48'h0000_0001_0000, 48'h0000_0000_4000,
          48'h0000_0010_0000, 48'hffff_fff0_0000);
    pending_beats.push_back(make_beat('1, 48'h7fff_ffff_ffff, 1'b1));
    pending_beats.push_back(make_beat('1, 48'h8000_0000_0000, 1'b1));
    pending_beats.push_back(make_beat('1, 48'h0000_0002_0000, 1'b1));

    // Random phases; the drain before each write also makes the sender wait for all results.
    repeat (22) begin
      case ($urandom_range(3))
        0: begin lo = '0; hi = '0; end
        1: begin lo = rand48(); hi = rand48(); end
        default: begin
          lo = PhysW'($signed($urandom_range(4000)) - 2000) <<< 16;
          hi = lo + (PhysW'($urandom_range(5000)) <<< 14);
        end
      endcase
      setup(6'($urandom_range(63)),
            ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24, 1)),
            ($urandom_range(1)) ? rand48() : PhysW'($signed($urandom_range(200)) - 100) <<< 16,
            ($urandom_range(7) == 0) ? rand48() :
              PhysW'($signed($urandom_range(6)) - 3) <<< $urandom_range(17, 12),
            lo, hi);
      repeat (25)
        pending_beats.push_back(make_beat({$urandom(), $urandom()}, scaled_value(),
                                          $urandom_range(9) != 0));
    end
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    wait_drained();
    stimulus_done = 1'b1;
    repeat (Latency + 10) @(posedge clk_i);
    $display("Covered %0d beats, %0d results checked, across 28 register settings.",
             accepted, checked);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cse_pkg.sv
hdl/cse_divider.sv
hdl/can_signal_encoder.sv
tb/can_signal_encoder_test.sv
